// File: design/window_box_match_assert.svh
// ----------------------------------------------------------------------------
// window_box_match_assert.svh
// Assertion macros for the window box matcher; empty when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef WINDOW_BOX_MATCH_ASSERT_SVH
`define WINDOW_BOX_MATCH_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, held off during reset
`define WBM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("window_box_match: implication check failed");

// next-cycle implication, held off during reset
`define WBM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("window_box_match: next-cycle check failed");

`else

`define WBM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define WBM_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: design/wbm_pkg.sv
// ----------------------------------------------------------------------------
// wbm_pkg
// Shared types, codes and helpers of the window box matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package wbm_pkg;

    // fixed field widths
    localparam int ACT_W   = 2;
    localparam int CLS_W   = 8;
    localparam int CFG_W   = 12;
    localparam int OUT_W   = 21;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int RIDX_W  = 3;

    // input actions
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ADD   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;

    // match methods
    localparam logic [1:0] METHOD_WHOLE  = 2'd0;
    localparam logic [1:0] METHOD_CENTER = 2'd1;

    // register indexes
    localparam logic [RIDX_W-1:0] REG_MATCH_METHOD = 3'd0;
    localparam logic [RIDX_W-1:0] REG_NORMALIZE    = 3'd1;
    localparam logic [RIDX_W-1:0] REG_FIELD_WIDTH  = 3'd2;
    localparam logic [RIDX_W-1:0] REG_FIELD_HEIGHT = 3'd3;
    localparam logic [RIDX_W-1:0] REG_REGION_LEFT  = 3'd4;
    localparam logic [RIDX_W-1:0] REG_REGION_TOP   = 3'd5;
    localparam logic [RIDX_W-1:0] REG_REGION_RIGHT = 3'd6;
    localparam logic [RIDX_W-1:0] REG_REGION_BOT   = 3'd7;

    // register file contents seen by the core
    typedef struct packed {
        logic [1:0]       match_method;
        logic             normalize_on;
        logic [CFG_W-1:0] field_width;
        logic [CFG_W-1:0] field_height;
        logic [CFG_W-1:0] region_left;
        logic [CFG_W-1:0] region_top;
        logic [CFG_W-1:0] region_right;
        logic [CFG_W-1:0] region_bottom;
    } cfg_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PREP,
        S_DIV,
        S_OUT
    } state_t;

    // wrap a sign-extended value to the result field width
    function automatic logic [OUT_W-1:0] to_out(input logic signed [63:0] v);
        return v[OUT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: design/wbm_if.sv
// ----------------------------------------------------------------------------
// wbm_if
// Valid/ready channels: command items in, match results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface wbm_cmd_if import wbm_pkg::*; #(
    parameter int COORD_BITS = 12
) ();
    logic                  valid;
    logic                  ready;
    logic [ACT_W-1:0]      action;
    logic [CLS_W-1:0]      box_class;
    logic [COORD_BITS-1:0] box_left;
    logic [COORD_BITS-1:0] box_top;
    logic [COORD_BITS-1:0] box_right;
    logic [COORD_BITS-1:0] box_bottom;
    logic [COORD_BITS-1:0] window_x;
    logic [COORD_BITS-1:0] window_y;

    modport source (
        output valid, action, box_class, box_left, box_top, box_right, box_bottom,
               window_x, window_y,
        input  ready
    );
    modport sink (
        input  valid, action, box_class, box_left, box_top, box_right, box_bottom,
               window_x, window_y,
        output ready
    );
endinterface

interface wbm_rsp_if import wbm_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    found;
    logic [CLS_W-1:0]        match_class;
    logic signed [OUT_W-1:0] rel_left;
    logic signed [OUT_W-1:0] rel_top;
    logic [OUT_W-1:0]        box_w;
    logic [OUT_W-1:0]        box_h;

    modport source (
        output valid, found, match_class, rel_left, rel_top, box_w, box_h,
        input  ready
    );
    modport sink (
        input  valid, found, match_class, rel_left, rel_top, box_w, box_h,
        output ready
    );
endinterface

`default_nettype wire

// File: design/wbm_regs.sv
// ----------------------------------------------------------------------------
// wbm_regs
// APB register file: method, normalization, field size, activation region.
// ----------------------------------------------------------------------------
`default_nettype none

module wbm_regs import wbm_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t              cfg_reg;
    logic              wr_en;
    logic [RIDX_W-1:0] ridx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign ridx   = paddr[ADDR_W-1:2];
    assign cfg    = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.match_method  <= METHOD_WHOLE;
            cfg_reg.normalize_on  <= 1'b0;
            cfg_reg.field_width   <= 12'd32;
            cfg_reg.field_height  <= 12'd32;
            cfg_reg.region_left   <= 12'd0;
            cfg_reg.region_top    <= 12'd0;
            cfg_reg.region_right  <= 12'd31;
            cfg_reg.region_bottom <= 12'd31;
        end
        else if (wr_en)
        begin
            unique case (ridx)
                REG_MATCH_METHOD: cfg_reg.match_method  <= pwdata[1:0];
                REG_NORMALIZE:    cfg_reg.normalize_on  <= pwdata[0];
                REG_FIELD_WIDTH:  cfg_reg.field_width   <= pwdata[CFG_W-1:0];
                REG_FIELD_HEIGHT: cfg_reg.field_height  <= pwdata[CFG_W-1:0];
                REG_REGION_LEFT:  cfg_reg.region_left   <= pwdata[CFG_W-1:0];
                REG_REGION_TOP:   cfg_reg.region_top    <= pwdata[CFG_W-1:0];
                REG_REGION_RIGHT: cfg_reg.region_right  <= pwdata[CFG_W-1:0];
                REG_REGION_BOT:   cfg_reg.region_bottom <= pwdata[CFG_W-1:0];
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (ridx)
            REG_MATCH_METHOD: prdata = DATA_W'(cfg_reg.match_method);
            REG_NORMALIZE:    prdata = DATA_W'(cfg_reg.normalize_on);
            REG_FIELD_WIDTH:  prdata = DATA_W'(cfg_reg.field_width);
            REG_FIELD_HEIGHT: prdata = DATA_W'(cfg_reg.field_height);
            REG_REGION_LEFT:  prdata = DATA_W'(cfg_reg.region_left);
            REG_REGION_TOP:   prdata = DATA_W'(cfg_reg.region_top);
            REG_REGION_RIGHT: prdata = DATA_W'(cfg_reg.region_right);
            REG_REGION_BOT:   prdata = DATA_W'(cfg_reg.region_bottom);
        endcase
    end

endmodule

`default_nettype wire

// File: design/wbm_store.sv
// ----------------------------------------------------------------------------
// wbm_store
// Box table memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module wbm_store #(
    parameter int DEPTH   = 32,
    parameter int ENTRY_W = 56,
    parameter int IDX_W   = 5
) (
    input  wire logic               clk,
    input  wire logic               wr_en,
    input  wire logic [IDX_W-1:0]   wr_addr,
    input  wire logic [ENTRY_W-1:0] wr_data,
    input  wire logic               rd_en,
    input  wire logic [IDX_W-1:0]   rd_addr,
    output logic      [ENTRY_W-1:0] rd_data
);

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    assign rd_data = rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: design/wbm_div.sv
// ----------------------------------------------------------------------------
// wbm_div
// Shared restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
`default_nettype none

module wbm_div #(
    parameter int NUM_W = 21,
    parameter int DEN_W = 12
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] dividend,
    input  wire logic [DEN_W-1:0] divisor,
    output logic                  done,
    output logic      [NUM_W-1:0] quotient
);

    localparam int CW = $clog2(NUM_W);

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;
    logic             fits;

    assign done     = done_reg;
    assign quotient = quo_reg;

    // one shift-subtract step
    always_comb
    begin
        trial     = {rem_reg, quo_reg[NUM_W-1]};
        fits      = trial >= {1'b0, den_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = CW'(NUM_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            den_reg <= divisor;
        end
    end

endmodule

`default_nettype wire

// File: design/window_box_match.sv
// ----------------------------------------------------------------------------
// window_box_match
// Ground-truth box table with first-match lookup against a shifted region.
// ----------------------------------------------------------------------------
// Clear and add items are taken in the idle state. A query scans the table
// through a registered memory read, one entry a cycle. With no match the
// result is ready to transfer once every stored entry has been read. A
// match ends the scan, and the four values are then prepared in turn:
// left offset, top offset, width, height. With normalization on, each value
// instead goes through the shared divider; sizes that saturate to zero skip
// their pass through the divider.
// The result is held until taken; the block accepts no item meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

`include "window_box_match_assert.svh"

module window_box_match import wbm_pkg::*; #(
    parameter int MAX_BOXES  = 32,
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    wbm_cmd_if.sink                cmd,
    wbm_rsp_if.source              rsp
);

    localparam int IDX_W   = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CNT_W   = $clog2(MAX_BOXES + 1);
    localparam int ENTRY_W = CLS_W + 4 * COORD_BITS;
    localparam int BND_W   = ((CFG_W > COORD_BITS) ? CFG_W : COORD_BITS) + 2;
    localparam int DIV_W   = COORD_BITS + FRAC_BITS + 1;
    localparam int VAL_W   = DIV_W + 1;

    cfg_t cfg;

    // registers
    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        issue_reg, issue_next;
    logic                    pend_reg, pend_next;
    logic [1:0]              k_reg, k_next;
    logic                    neg_reg;
    logic [COORD_BITS-1:0]   wx_reg, wy_reg;
    logic [BND_W-1:0]        rl_reg, rt_reg, rr_reg, rb_reg;
    logic                    found_reg;
    logic [CLS_W-1:0]        cls_reg;
    logic [COORD_BITS-1:0]   hl_reg, ht_reg, hr_reg, hb_reg;
    logic [OUT_W-1:0]        res_reg [4];

    // handshake and control
    logic                    cmd_xfer;
    logic                    rsp_xfer;
    logic                    is_query;
    logic                    is_add;
    logic                    wr_en;
    logic                    rd_en;
    logic [ENTRY_W-1:0]      rd_data;
    logic                    hit;
    logic                    scan_end;
    logic                    div_start;
    logic                    div_done;
    logic [DIV_W-1:0]        div_quotient;
    logic                    store_direct;
    logic                    store_div;

    // scan entry fields
    logic [CLS_W-1:0]        e_cls;
    logic [COORD_BITS-1:0]   e_l, e_t, e_r, e_b;
    logic                    in_region;

    // value preparation
    logic [COORD_BITS-1:0]   opa, opb;
    logic signed [VAL_W-1:0] base_s, scaled_s, mag_s, direct_s, quot_s, div_res_s;
    logic                    size_zero;
    logic [CFG_W-1:0]        divisor;

    assign cmd_xfer = cmd.valid && cmd.ready;
    assign rsp_xfer = rsp.valid && rsp.ready;
    assign is_query = cmd.action == ACT_QUERY;
    assign is_add   = cmd.action == ACT_ADD;

    wbm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    wbm_store #(
        .DEPTH   (MAX_BOXES),
        .ENTRY_W (ENTRY_W),
        .IDX_W   (IDX_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data ({cmd.box_class, cmd.box_left, cmd.box_top, cmd.box_right,
                   cmd.box_bottom}),
        .rd_en   (rd_en),
        .rd_addr (issue_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    wbm_div #(
        .NUM_W (DIV_W),
        .DEN_W (CFG_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mag_s[DIV_W-1:0]),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // region test on the entry read last cycle
    assign {e_cls, e_l, e_t, e_r, e_b} = rd_data;

    always_comb
    begin
        unique case (cfg.match_method)
            METHOD_WHOLE:
                in_region = (BND_W'(e_l) >= rl_reg) && (BND_W'(e_r) <= rr_reg) &&
                            (BND_W'(e_t) >= rt_reg) && (BND_W'(e_b) <= rb_reg);
            METHOD_CENTER:
                in_region = (BND_W'(e_l) + BND_W'(e_r) >= {rl_reg[BND_W-2:0], 1'b0}) &&
                            (BND_W'(e_l) + BND_W'(e_r) <= {rr_reg[BND_W-2:0], 1'b0}) &&
                            (BND_W'(e_t) + BND_W'(e_b) >= {rt_reg[BND_W-2:0], 1'b0}) &&
                            (BND_W'(e_t) + BND_W'(e_b) <= {rb_reg[BND_W-2:0], 1'b0});
            default:
                in_region = 1'b0;
        endcase
    end

    assign hit      = (state_reg == S_SCAN) && pend_reg && in_region;
    assign scan_end = (issue_reg == count_reg) && !pend_reg;

    // operand selection: offsets for k = 0,1, sizes for k = 2,3
    always_comb
    begin
        unique case (k_reg)
            2'd0:    begin opa = hl_reg; opb = wx_reg; end
            2'd1:    begin opa = ht_reg; opb = wy_reg; end
            2'd2:    begin opa = hr_reg; opb = hl_reg; end
            default: begin opa = hb_reg; opb = ht_reg; end
        endcase
        base_s    = $signed(VAL_W'(opa)) - $signed(VAL_W'(opb)) +
                    $signed(VAL_W'(k_reg[1]));
        size_zero = k_reg[1] && (base_s <= 0);
        scaled_s  = base_s <<< FRAC_BITS;
        mag_s     = scaled_s[VAL_W-1] ? -scaled_s : scaled_s;
        direct_s  = size_zero ? '0 : scaled_s;
        quot_s    = $signed({1'b0, div_quotient});
        div_res_s = neg_reg ? -quot_s : quot_s;
        divisor   = k_reg[0] ? cfg.field_height : cfg.field_width;
        if (divisor == '0)
        begin
            divisor = CFG_W'(1);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (cmd_xfer && is_query)
                begin
                    state_next = S_SCAN;
                end
            S_SCAN:
                if (hit)
                begin
                    state_next = S_PREP;
                end
                else if (scan_end)
                begin
                    state_next = S_OUT;
                end
            S_PREP:
                if (!(cfg.normalize_on && !size_zero))
                begin
                    state_next = (k_reg == 2'd3) ? S_OUT : S_PREP;
                end
                else
                begin
                    state_next = S_DIV;
                end
            S_DIV:
                if (div_done)
                begin
                    state_next = (k_reg == 2'd3) ? S_OUT : S_PREP;
                end
            S_OUT:
                if (rsp_xfer)
                begin
                    state_next = S_IDLE;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        cmd.ready    = 1'b0;
        rsp.valid    = 1'b0;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        div_start    = 1'b0;
        store_direct = 1'b0;
        store_div    = 1'b0;
        count_next   = count_reg;
        issue_next   = issue_reg;
        pend_next    = 1'b0;
        k_next       = k_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.ready  = 1'b1;
                issue_next = '0;
                k_next     = 2'd0;
                if (cmd_xfer && cmd.action == ACT_CLEAR)
                begin
                    count_next = '0;
                end
                else if (cmd_xfer && is_add && (count_reg < CNT_W'(MAX_BOXES)))
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            S_SCAN:
                if (!hit && (issue_reg != count_reg))
                begin
                    rd_en      = 1'b1;
                    issue_next = issue_reg + CNT_W'(1);
                    pend_next  = 1'b1;
                end
            S_PREP:
                if (cfg.normalize_on && !size_zero)
                begin
                    div_start = 1'b1;
                end
                else
                begin
                    store_direct = 1'b1;
                    k_next       = k_reg + 2'd1;
                end
            S_DIV:
                if (div_done)
                begin
                    store_div = 1'b1;
                    k_next    = k_reg + 2'd1;
                end
            S_OUT:
                rsp.valid = 1'b1;
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            issue_reg <= '0;
            pend_reg  <= 1'b0;
            k_reg     <= 2'd0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            issue_reg <= issue_next;
            pend_reg  <= pend_next;
            k_reg     <= k_next;
            if (cmd_xfer)
            begin
                found_reg <= 1'b0;
            end
            else if (hit)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    // query window, shifted region, matched entry and results
    always_ff @(posedge clk)
    begin
        if (cmd_xfer && is_query)
        begin
            wx_reg     <= cmd.window_x;
            wy_reg     <= cmd.window_y;
            rl_reg     <= BND_W'(cfg.region_left) + BND_W'(cmd.window_x);
            rr_reg     <= BND_W'(cfg.region_right) + BND_W'(cmd.window_x);
            rt_reg     <= BND_W'(cfg.region_top) + BND_W'(cmd.window_y);
            rb_reg     <= BND_W'(cfg.region_bottom) + BND_W'(cmd.window_y);
            cls_reg    <= '0;
            res_reg[0] <= '0;
            res_reg[1] <= '0;
            res_reg[2] <= '0;
            res_reg[3] <= '0;
        end
        if (hit)
        begin
            cls_reg <= e_cls;
            hl_reg  <= e_l;
            ht_reg  <= e_t;
            hr_reg  <= e_r;
            hb_reg  <= e_b;
        end
        if (div_start)
        begin
            neg_reg <= scaled_s[VAL_W-1];
        end
        if (store_direct)
        begin
            res_reg[k_reg] <= to_out(64'(direct_s));
        end
        else if (store_div)
        begin
            res_reg[k_reg] <= to_out(64'(div_res_s));
        end
    end

    // result payload
    assign rsp.found       = found_reg;
    assign rsp.match_class = cls_reg;
    assign rsp.rel_left    = $signed(res_reg[0]);
    assign rsp.rel_top     = $signed(res_reg[1]);
    assign rsp.box_w       = res_reg[2];
    assign rsp.box_h       = res_reg[3];

    // checks
    `WBM_ASSERT_IMP(a_no_accept_while_holding, clk, rst_n, rsp.valid, !cmd.ready)
    `WBM_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(MAX_BOXES))
    `WBM_ASSERT_NXT(a_hit_to_prep, clk, rst_n, hit, state_reg == S_PREP && found_reg)
    `WBM_ASSERT_IMP(a_div_start_ctx, clk, rst_n, div_start,
                    state_reg == S_PREP && cfg.normalize_on)

endmodule

`default_nettype wire

// File: dv/window_box_match_tb.sv
// ----------------------------------------------------------------------------
// window_box_match_tb
// Self-checking bench for the ground-truth window box matcher.
// ----------------------------------------------------------------------------
// A short directed table covers the corners: empty and full table, dropped
// adds, inverted boxes, both match methods, the never-match codes, zero and
// maximum field sizes. Random phases then reprogram the registers and send
// clear/add/query sequences, with queries mostly aimed at stored boxes so
// that matches are frequent. Every query result is compared against an
// expected value from the directed table or an in-bench predictor of the
// matcher, with random gaps and stalls on both channels but in quiet phases.
// ----------------------------------------------------------------------------
`default_nettype none

module window_box_match_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wbm_pkg::*;

    localparam int MAX_BOXES   = 32;
    localparam int COORD_BITS  = 12;
    localparam int FRAC_BITS   = 8;
    localparam int N_PHASES    = 12;
    localparam int PHASE_ITEMS = 155;
    localparam int SETTLE      = 4;      // clear/add are taken without leaving the idle state
    localparam int DRAIN       = 200;    // longer than a full scan plus four divides
    localparam int LIMIT       = 1_500_000;

    // codes the package leaves unnamed
    localparam logic [1:0]       METHOD_NEVER = 2'd2;
    localparam logic [1:0]       METHOD_SPARE = 2'd3;
    localparam logic [ACT_W-1:0] ACT_IGNORED  = 2'd3;

    typedef struct packed {
        logic [ACT_W-1:0]      action;
        logic [CLS_W-1:0]      box_class;
        logic [COORD_BITS-1:0] left;
        logic [COORD_BITS-1:0] top;
        logic [COORD_BITS-1:0] right;
        logic [COORD_BITS-1:0] bottom;
        logic [COORD_BITS-1:0] wx;
        logic [COORD_BITS-1:0] wy;
    } cmd_t;

    typedef struct packed {
        logic             found;
        logic [CLS_W-1:0] match_class;
        logic [OUT_W-1:0] rel_left;
        logic [OUT_W-1:0] rel_top;
        logic [OUT_W-1:0] box_w;
        logic [OUT_W-1:0] box_h;
    } res_t;

    typedef struct packed {
        logic [CLS_W-1:0]      cls;
        logic [COORD_BITS-1:0] left;
        logic [COORD_BITS-1:0] top;
        logic [COORD_BITS-1:0] right;
        logic [COORD_BITS-1:0] bottom;
    } gt_box_t;

    typedef enum {ROW_CMD, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t         kind;
        int                reps;
        cmd_t              c;
        bit                typed;
        res_t              exp;
        logic [RIDX_W-1:0] idx;
        logic [CFG_W-1:0]  val;
    } row_t;

    localparam res_t NO_HIT = '0;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    wbm_cmd_if #(.COORD_BITS(COORD_BITS)) cmd_ch ();
    wbm_rsp_if rsp_ch ();

    window_box_match #(
        .MAX_BOXES  (MAX_BOXES),
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cmd     (cmd_ch),
        .rsp     (rsp_ch)
    );

    // predictor state: box table, fill count and register copy
    gt_box_t box_tbl [MAX_BOXES];
    int      box_fill;
    cfg_t    shadow_cfg;
    res_t    match_q [$];
    row_t    dir_rows [$];

    int errors;
    int n_items;
    int n_queries;
    int n_hits;
    int n_drops;
    int n_reg_writes;
    int cycle_cnt;
    bit quiet;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // integer to Q.8, optionally divided by the field size (trunc to zero)
    function automatic longint to_q8(input longint v, input logic [CFG_W-1:0] div);
        longint q;
        q = v <<< FRAC_BITS;
        if (!shadow_cfg.normalize_on)
            return q;
        return q / ((div == 0) ? 64'sd1 : longint'(div));
    endfunction

    // first stored box matching the shifted region
    function automatic res_t match_window(input logic [COORD_BITS-1:0] wx,
                                          input logic [COORD_BITS-1:0] wy);
        res_t   r;
        longint lo_x, lo_y, hi_x, hi_y;
        longint l, t, rgt, bot, w, h;
        bit     hit;
        r    = NO_HIT;
        lo_x = longint'(shadow_cfg.region_left) + longint'(wx);
        lo_y = longint'(shadow_cfg.region_top) + longint'(wy);
        hi_x = longint'(shadow_cfg.region_right) + longint'(wx);
        hi_y = longint'(shadow_cfg.region_bottom) + longint'(wy);
        for (int i = 0; i < box_fill; i++)
        begin
            l   = longint'(box_tbl[i].left);
            t   = longint'(box_tbl[i].top);
            rgt = longint'(box_tbl[i].right);
            bot = longint'(box_tbl[i].bottom);
            case (shadow_cfg.match_method)
                METHOD_WHOLE:  hit = l >= lo_x && rgt <= hi_x && t >= lo_y && bot <= hi_y;
                METHOD_CENTER: hit = (l + rgt) >= 2 * lo_x && (l + rgt) <= 2 * hi_x &&
                                     (t + bot) >= 2 * lo_y && (t + bot) <= 2 * hi_y;
                default:       hit = 1'b0;
            endcase
            if (hit)
            begin
                w = rgt - l + 1;
                h = bot - t + 1;
                r.found       = 1'b1;
                r.match_class = box_tbl[i].cls;
                r.rel_left    = OUT_W'(to_q8(l - longint'(wx), shadow_cfg.field_width));
                r.rel_top     = OUT_W'(to_q8(t - longint'(wy), shadow_cfg.field_height));
                r.box_w       = (w > 0) ? OUT_W'(to_q8(w, shadow_cfg.field_width)) : '0;
                r.box_h       = (h > 0) ? OUT_W'(to_q8(h, shadow_cfg.field_height)) : '0;
                return r;
            end
        end
        return r;
    endfunction

    // update table state for an accepted transfer, queue the expected result
    function automatic void apply_cmd(input cmd_t c, input bit typed, input res_t exp);
        res_t want;
        case (c.action)
            ACT_CLEAR: box_fill = 0;
            ACT_ADD:
            begin
                if (box_fill < MAX_BOXES)
                begin
                    box_tbl[box_fill] = '{c.box_class, c.left, c.top, c.right, c.bottom};
                    box_fill++;
                end
                else
                    n_drops++;
            end
            ACT_QUERY:
            begin
                want = typed ? exp : match_window(c.wx, c.wy);
                match_q.insert(match_q.size(), want);
                n_queries++;
            end
            default: ;
        endcase
        if (c.action != ACT_IGNORED)
            n_items++;
    endfunction

    // ------------------------------------------------------------------
    // item builders
    // ------------------------------------------------------------------

    function automatic cmd_t query_at(input logic [COORD_BITS-1:0] wx,
                                      input logic [COORD_BITS-1:0] wy);
        cmd_t c;
        c        = '0;
        c.action = ACT_QUERY;
        c.wx     = wx;
        c.wy     = wy;
        return c;
    endfunction

    function automatic cmd_t add_box(input logic [CLS_W-1:0] cls,
                                     input logic [COORD_BITS-1:0] l,
                                     input logic [COORD_BITS-1:0] t,
                                     input logic [COORD_BITS-1:0] r,
                                     input logic [COORD_BITS-1:0] b);
        cmd_t c;
        c           = '0;
        c.action    = ACT_ADD;
        c.box_class = cls;
        c.left      = l;
        c.top       = t;
        c.right     = r;
        c.bottom    = b;
        return c;
    endfunction

    function automatic logic [COORD_BITS-1:0] clamp12(input int v);
        if (v < 0)
            return '0;
        if (v > 4095)
            return '1;
        return COORD_BITS'(v);
    endfunction

    function automatic cmd_t rand_box(input bit clustered, input int bx, input int by);
        int l, t, r, b, kind;
        l    = clustered ? bx + int'($urandom_range(0, 40)) : int'($urandom_range(0, 4095));
        t    = clustered ? by + int'($urandom_range(0, 40)) : int'($urandom_range(0, 4095));
        kind = $urandom_range(0, 99);
        if (kind < 72)
        begin
            r = l + int'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 400)
                                                      : $urandom_range(0, 48));
            b = t + int'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 400)
                                                      : $urandom_range(0, 48));
        end
        else if (kind < 86)
        begin
            // inverted corners
            r = l - int'($urandom_range(1, 40));
            b = t - int'($urandom_range(1, 40));
        end
        else
        begin
            r = $urandom_range(0, 4095);
            b = $urandom_range(0, 4095);
        end
        return add_box(CLS_W'($urandom), clamp12(l), clamp12(t), clamp12(r), clamp12(b));
    endfunction

    // mostly aimed so that a stored box falls into the shifted region
    function automatic cmd_t rand_query();
        int      wx, wy;
        gt_box_t e;
        if (box_fill > 0 && $urandom_range(0, 9) < 7)
        begin
            e  = box_tbl[$urandom_range(0, box_fill - 1)];
            wx = int'(e.left) - int'(shadow_cfg.region_left) - int'($urandom_range(0, 6));
            wy = int'(e.top) - int'(shadow_cfg.region_top) - int'($urandom_range(0, 6));
        end
        else
        begin
            wx = $urandom_range(0, 4095);
            wy = $urandom_range(0, 4095);
        end
        return query_at(clamp12(wx), clamp12(wy));
    endfunction

    function automatic row_t cmd_row(input cmd_t c, input bit typed = 1'b0,
                                     input res_t exp = '0, input int reps = 1);
        row_t r;
        r.kind  = ROW_CMD;
        r.reps  = reps;
        r.c     = c;
        r.typed = typed;
        r.exp   = exp;
        r.idx   = '0;
        r.val   = '0;
        return r;
    endfunction

    function automatic row_t reg_row(input logic [RIDX_W-1:0] idx,
                                     input logic [CFG_W-1:0] val);
        row_t r;
        r       = cmd_row('0);
        r.kind  = ROW_REG;
        r.idx   = idx;
        r.val   = val;
        return r;
    endfunction

    // append one row to the directed table
    function automatic void append_row(input row_t r);
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // idle length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(13, 40);
    endfunction

    task automatic flag(input string msg);
        errors++;
        if (errors <= 10)
            $display("%s", msg);
    endtask

    function automatic string show(input res_t r);
        return $sformatf("found=%0b class=%02h rel_left=%0d rel_top=%0d w=%0d h=%0d",
                         r.found, r.match_class, $signed(r.rel_left), $signed(r.rel_top),
                         r.box_w, r.box_h);
    endfunction

    task automatic send_cmd(input cmd_t c, input bit typed = 1'b0, input res_t exp = '0);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.action     <= c.action;
        cmd_ch.box_class  <= c.box_class;
        cmd_ch.box_left   <= c.left;
        cmd_ch.box_top    <= c.top;
        cmd_ch.box_right  <= c.right;
        cmd_ch.box_bottom <= c.bottom;
        cmd_ch.window_x   <= c.wx;
        cmd_ch.window_y   <= c.wy;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        apply_cmd(c, typed, exp);
    endtask

    // stop sending and wait until every query result is back
    task automatic idle_and_drain();
        cmd_ch.valid <= 1'b0;
        while (match_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // register write followed by a readback; block must be idle
    task automatic set_reg(input logic [RIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        logic [DATA_W-1:0] want;
        case (idx)
            REG_MATCH_METHOD: shadow_cfg.match_method  = val[1:0];
            REG_NORMALIZE:    shadow_cfg.normalize_on  = val[0];
            REG_FIELD_WIDTH:  shadow_cfg.field_width   = val;
            REG_FIELD_HEIGHT: shadow_cfg.field_height  = val;
            REG_REGION_LEFT:  shadow_cfg.region_left   = val;
            REG_REGION_TOP:   shadow_cfg.region_top    = val;
            REG_REGION_RIGHT: shadow_cfg.region_right  = val;
            REG_REGION_BOT:   shadow_cfg.region_bottom = val;
            default: ;
        endcase
        case (idx)
            REG_MATCH_METHOD: want = DATA_W'(val[1:0]);
            REG_NORMALIZE:    want = DATA_W'(val[0]);
            default:          want = DATA_W'(val);
        endcase
        // write: setup then access
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= DATA_W'(val);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        // read back the same register
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== want)
            flag($sformatf("register %0d readback: expected %h, got %h", idx, want, prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
        n_reg_writes++;
    endtask

    // program every register for one random phase
    task automatic config_phase(input int p);
        logic [1:0]       m;
        logic             n;
        logic [CFG_W-1:0] fw, fh, rl, rt, rr, rb;
        m  = METHOD_WHOLE;
        n  = 1'b0;
        fw = 12'd32;
        fh = 12'd32;
        rl = 12'd0;
        rt = 12'd0;
        rr = 12'd31;
        rb = 12'd31;
        case (p)
            0: ;
            1:
            begin
                m  = METHOD_CENTER;
                n  = 1'b1;
                fh = 12'd24;
            end
            2:
            begin
                n  = 1'b1;
                fw = 12'd1;
                fh = 12'd1;
                rr = 12'd4095;
                rb = 12'd4095;
            end
            3:
            begin
                m  = METHOD_CENTER;
                n  = 1'b1;
                fw = 12'd4095;
                fh = 12'd4095;
                rl = 12'd4095;
                rt = 12'd4095;
                rr = 12'd4095;
                rb = 12'd4095;
            end
            4:
            begin
                m = METHOD_NEVER;
                n = 1'($urandom_range(0, 1));
            end
            5: m = METHOD_SPARE;
            6:
            begin
                // region with left past right
                m  = 2'($urandom_range(0, 1));
                rl = 12'd40;
                rt = 12'd40;
                rr = 12'd10;
                rb = 12'd10;
            end
            7:
            begin
                n  = 1'b1;
                fw = 12'd0;
                fh = 12'd0;
            end
            default:
            begin
                m  = ($urandom_range(0, 9) < 8) ? 2'($urandom_range(0, 1))
                                                : 2'($urandom_range(2, 3));
                n  = 1'($urandom_range(0, 1));
                fw = ($urandom_range(0, 1) == 0) ? 12'($urandom) : 12'($urandom_range(1, 64));
                fh = ($urandom_range(0, 1) == 0) ? 12'($urandom) : 12'($urandom_range(1, 64));
                if ($urandom_range(0, 4) == 0)
                begin
                    rl = 12'($urandom);
                    rt = 12'($urandom);
                    rr = 12'($urandom);
                    rb = 12'($urandom);
                end
                else
                begin
                    rl = 12'($urandom_range(0, 64));
                    rt = 12'($urandom_range(0, 64));
                    rr = rl + 12'($urandom_range(0, 96));
                    rb = rt + 12'($urandom_range(0, 96));
                end
            end
        endcase
        set_reg(REG_MATCH_METHOD, CFG_W'(m));
        set_reg(REG_NORMALIZE, CFG_W'(n));
        set_reg(REG_FIELD_WIDTH, fw);
        set_reg(REG_FIELD_HEIGHT, fh);
        set_reg(REG_REGION_LEFT, rl);
        set_reg(REG_REGION_TOP, rt);
        set_reg(REG_REGION_RIGHT, rr);
        set_reg(REG_REGION_BOT, rb);
    endtask

    // ------------------------------------------------------------------
    // result side: random stalls, compare with oldest expectation
    // ------------------------------------------------------------------
    initial
    begin
        int   hold;
        res_t got;
        res_t want;
        hold = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got = '{rsp_ch.found, rsp_ch.match_class, rsp_ch.rel_left, rsp_ch.rel_top,
                        rsp_ch.box_w, rsp_ch.box_h};
                if (match_q.size() == 0)
                    flag({"unexpected result: ", show(got)});
                else
                begin
                    want = match_q.pop_front();
                    if (want.found)
                        n_hits++;
                    if (got !== want)
                        flag({"mismatch: expected ", show(want), " / got ", show(got)});
                end
            end
            if (hold == 0 && !quiet && $urandom_range(0, 5) == 0)
                hold = pick_gap();
            if (hold > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold--;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // watchdog
    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, match_q.size());
        $display("window_box_match test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int stop;
        int k;
        int bx;
        int by;
        bit clustered;
        cmd_t c;

        rst_n             <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        cmd_ch.valid      <= 1'b0;
        cmd_ch.action     <= ACT_CLEAR;
        cmd_ch.box_class  <= '0;
        cmd_ch.box_left   <= '0;
        cmd_ch.box_top    <= '0;
        cmd_ch.box_right  <= '0;
        cmd_ch.box_bottom <= '0;
        cmd_ch.window_x   <= '0;
        cmd_ch.window_y   <= '0;

        box_fill     = 0;
        shadow_cfg   = '{METHOD_WHOLE, 1'b0, 12'd32, 12'd32, 12'd0, 12'd0, 12'd31, 12'd31};
        errors       = 0;
        n_items      = 0;
        n_queries    = 0;
        n_hits       = 0;
        n_drops      = 0;
        n_reg_writes = 0;
        quiet        = 1'b0;

        // directed table; defaults: whole mode, region 0..31, no normalization
        append_row(cmd_row(query_at(12'd0, 12'd0), 1'b1, NO_HIT));
        append_row(cmd_row(query_at(12'd4095, 12'd4095), 1'b1, NO_HIT));
        append_row(cmd_row(add_box(8'hA5, 12'd0, 12'd0, 12'd31, 12'd31)));
        append_row(cmd_row(query_at(12'd0, 12'd0), 1'b1,
                           '{1'b1, 8'hA5, 21'd0, 21'd0, 21'd8192, 21'd8192}));
        append_row(cmd_row('{action: ACT_IGNORED, default: '1}));
        append_row(cmd_row(add_box(8'hFF, 12'd4095, 12'd4095, 12'd4095, 12'd4095)));
        append_row(cmd_row(query_at(12'd4064, 12'd4064), 1'b1,
                           '{1'b1, 8'hFF, 21'd7936, 21'd7936, 21'd256, 21'd256}));
        append_row(cmd_row(query_at(12'd4095, 12'd4095), 1'b1,
                           '{1'b1, 8'hFF, 21'd0, 21'd0, 21'd256, 21'd256}));
        append_row(cmd_row('{action: ACT_CLEAR, default: '1}));
        append_row(cmd_row(query_at(12'd0, 12'd0), 1'b1, NO_HIT));
        // inverted box: sizes saturate to zero
        append_row(cmd_row(add_box(8'h5A, 12'd20, 12'd20, 12'd10, 12'd10)));
        append_row(cmd_row(query_at(12'd0, 12'd0), 1'b1,
                           '{1'b1, 8'h5A, 21'd5120, 21'd5120, 21'd0, 21'd0}));
        append_row(cmd_row(query_at(12'd30, 12'd30), 1'b1, NO_HIT));
        // fill the table, then an add that must be dropped
        append_row(cmd_row('{action: ACT_CLEAR, default: '0}));
        append_row(cmd_row(add_box(8'h11, 12'd2000, 12'd2000, 12'd2010, 12'd2010),
                           1'b0, NO_HIT, MAX_BOXES));
        append_row(cmd_row(add_box(8'h22, 12'd0, 12'd0, 12'd0, 12'd0)));
        append_row(cmd_row(query_at(12'd0, 12'd0), 1'b1, NO_HIT));
        append_row(cmd_row(query_at(12'd2000, 12'd2000), 1'b1,
                           '{1'b1, 8'h11, 21'd0, 21'd0, 21'd2816, 21'd2816}));
        // center mode, box left of the window
        append_row(reg_row(REG_MATCH_METHOD, CFG_W'(METHOD_CENTER)));
        append_row(cmd_row('{action: ACT_CLEAR, default: '0}));
        append_row(cmd_row(add_box(8'h33, 12'd0, 12'd0, 12'd9, 12'd9)));
        append_row(cmd_row(query_at(12'd3, 12'd3), 1'b1,
                           '{1'b1, 8'h33, -21'sd768, -21'sd768, 21'd2560, 21'd2560}));
        // normalization with a zero and a maximal divisor
        append_row(reg_row(REG_NORMALIZE, 12'd1));
        append_row(reg_row(REG_FIELD_WIDTH, 12'd0));
        append_row(reg_row(REG_FIELD_HEIGHT, 12'd4095));
        append_row(cmd_row(query_at(12'd3, 12'd3)));
        // both never-match method codes
        append_row(reg_row(REG_MATCH_METHOD, CFG_W'(METHOD_NEVER)));
        append_row(cmd_row(query_at(12'd3, 12'd3), 1'b1, NO_HIT));
        append_row(reg_row(REG_MATCH_METHOD, CFG_W'(METHOD_SPARE)));
        append_row(cmd_row(query_at(12'd3, 12'd3), 1'b1, NO_HIT));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_REG)
            begin
                idle_and_drain();
                set_reg(dir_rows[i].idx, dir_rows[i].val);
            end
            else
                repeat (dir_rows[i].reps)
                    send_cmd(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].exp);
        end

        // random phases, each with its own register setting
        for (int p = 0; p < N_PHASES; p++)
        begin
            idle_and_drain();
            quiet = (p % 5 == 2);
            config_phase(p);
            stop = n_items + PHASE_ITEMS;
            while (n_items < stop)
            begin
                if ($urandom_range(0, 99) < 85)
                begin
                    // mostly a clear, then a run of adds and a few queries
                    if ($urandom_range(0, 4) != 0)
                        send_cmd('{action: ACT_CLEAR, default: '0});
                    k         = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 34)
                                                            : $urandom_range(1, 8);
                    clustered = $urandom_range(0, 1);
                    bx        = $urandom_range(0, 4000);
                    by        = $urandom_range(0, 4000);
                    repeat (k) send_cmd(rand_box(clustered, bx, by));
                    repeat ($urandom_range(1, 6)) send_cmd(rand_query());
                end
                else
                begin
                    // noise: any action, any field values
                    c.action    = ACT_W'($urandom_range(0, 3));
                    c.box_class = CLS_W'($urandom);
                    c.left      = COORD_BITS'($urandom);
                    c.top       = COORD_BITS'($urandom);
                    c.right     = COORD_BITS'($urandom);
                    c.bottom    = COORD_BITS'($urandom);
                    c.wx        = COORD_BITS'($urandom);
                    c.wy        = COORD_BITS'($urandom);
                    send_cmd(c);
                end
                // occasionally hold off until the result queue is empty
                if ($urandom_range(0, 39) == 0)
                    idle_and_drain();
            end
        end

        idle_and_drain();
        repeat (DRAIN) @(posedge clk);

        $display("run covered %0d transfers in, %0d queries (%0d matches), %0d dropped adds",
                 n_items, n_queries, n_hits, n_drops);
        $display("%0d register writes over %0d phases, %0d errors found",
                 n_reg_writes, N_PHASES, errors);
        if (errors == 0)
            $display("window_box_match test passed");
        else
            $display("window_box_match test failed");
        $finish;
    end

endmodule

`default_nettype wire
